/* hw/rtl/scm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scm_pkg
// Shared widths, merge mode codes and result types for the sorted
// coordinate duplicate merger.
// ----------------------------------------------------------------------------
package scm_pkg;

   localparam int INDEX_WIDTH = 31;
   localparam int VALUE_WIDTH = 32;
   localparam int COUNT_WIDTH = 31;
   localparam int MODE_WIDTH  = 2;

   typedef logic [MODE_WIDTH-1:0] mode_type;

   localparam mode_type MODE_KEEP_FIRST = 2'd0;
   localparam mode_type MODE_KEEP_LAST  = 2'd1;
   localparam mode_type MODE_SUM        = 2'd2;

   typedef logic        [INDEX_WIDTH-1:0] index_type;
   typedef logic signed [VALUE_WIDTH-1:0] value_type;
   typedef logic        [COUNT_WIDTH-1:0] count_type;

   // One merged entry on its way to the result channel
   typedef struct packed {
      index_type row;
      index_type col;
      value_type value;
      logic      end_of_stream;
      count_type removed_count;
   } result_type;

   // Up to two results produced by one accepted entry, oldest first
   typedef struct packed {
      logic       first_valid;
      result_type first;
      logic       second_valid;
      result_type second;
   } push_type;

endpackage

/* hw/rtl/scm_merge.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scm_merge
// Holds the pending entry, compares each accepted entry against it, folds
// duplicates per merge mode and hands emitted entries to the result queue.
// ----------------------------------------------------------------------------
module scm_merge (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  scm_pkg::index_type  row,
   input  scm_pkg::index_type  col,
   input  scm_pkg::value_type  value,
   input  logic                last_item,
   input  scm_pkg::mode_type   merge_mode,
   output scm_pkg::push_type   push
);
   import scm_pkg::*;

   localparam count_type COUNT_MAX = {COUNT_WIDTH{1'b1}};
   localparam value_type VALUE_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
   localparam value_type VALUE_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

   index_type pend_row_ff,   pend_row_in;
   index_type pend_col_ff,   pend_col_in;
   value_type pend_value_ff, pend_value_in;
   logic      pend_valid_ff, pend_valid_in;
   count_type dup_count_ff,  dup_count_in;

   logic      hit;
   value_type sum_wrap;
   value_type sum_sat;
   value_type merged_value;
   count_type dup_next;
   index_type next_row;
   index_type next_col;
   value_type next_value;

   // Match against the held entry
   assign hit = pend_valid_ff && (row == pend_row_ff) && (col == pend_col_ff);

   // Saturating sum: clamp when both operands share a sign the sum lost
   always_comb begin
      sum_wrap = pend_value_ff + value;
      sum_sat  = sum_wrap;
      if ((pend_value_ff[VALUE_WIDTH-1] == value[VALUE_WIDTH-1]) &&
          (sum_wrap[VALUE_WIDTH-1] != pend_value_ff[VALUE_WIDTH-1])) begin
         sum_sat = pend_value_ff[VALUE_WIDTH-1] ? VALUE_MIN : VALUE_MAX;
      end
   end

   // Select the folded value; the unused mode keeps the first value
   always_comb begin
      case (merge_mode)
         MODE_KEEP_LAST: merged_value = value;
         MODE_SUM:       merged_value = sum_sat;
         default:        merged_value = pend_value_ff;
      endcase
   end

   // Count duplicates, holding at all ones
   assign dup_next = (hit && (dup_count_ff != COUNT_MAX)) ? dup_count_ff + 1'b1
                                                          : dup_count_ff;

   // Entry held after this item, before any flush
   assign next_row   = hit ? pend_row_ff : row;
   assign next_col   = hit ? pend_col_ff : col;
   assign next_value = hit ? merged_value : value;

   // Emit the old entry on a coordinate change, the new one on the last item
   always_comb begin
      push.first_valid                = accept && !hit && pend_valid_ff;
      push.first.row                  = pend_row_ff;
      push.first.col                  = pend_col_ff;
      push.first.value                = pend_value_ff;
      push.first.end_of_stream        = 1'b0;
      push.first.removed_count        = '0;
      push.second_valid               = accept && last_item;
      push.second.row                 = next_row;
      push.second.col                 = next_col;
      push.second.value               = next_value;
      push.second.end_of_stream       = 1'b1;
      push.second.removed_count       = dup_next;
   end

   // Advance the held entry; clear it after a flush
   always_comb begin
      pend_row_in   = pend_row_ff;
      pend_col_in   = pend_col_ff;
      pend_value_in = pend_value_ff;
      pend_valid_in = pend_valid_ff;
      dup_count_in  = dup_count_ff;
      if (accept) begin
         pend_row_in   = next_row;
         pend_col_in   = next_col;
         pend_value_in = next_value;
         pend_valid_in = !last_item;
         dup_count_in  = last_item ? '0 : dup_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         dup_count_ff  <= '0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         dup_count_ff  <= dup_count_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_row_ff   <= pend_row_in;
      pend_col_ff   <= pend_col_in;
      pend_value_ff <= pend_value_in;
   end

endmodule

/* hw/rtl/scm_out_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scm_out_queue
// Four-entry result queue: takes up to two results per cycle, hands one per
// cycle to a ready result channel, and has room whenever two more fit.
// ----------------------------------------------------------------------------
module scm_out_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  scm_pkg::push_type    push,
   output logic                 has_room,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output scm_pkg::result_type  rsp_data
);
   import scm_pkg::*;

   localparam int DEPTH     = 4;
   localparam int PTR_WIDTH = $clog2(DEPTH);
   localparam int CNT_WIDTH = $clog2(DEPTH + 1);

   result_type                 entry_ff [DEPTH];
   logic       [PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic       [PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic       [CNT_WIDTH-1:0] count_ff,  count_in;
   logic       [PTR_WIDTH-1:0] second_addr;
   logic                       pop;

   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = entry_ff[rd_ptr_ff];
   assign pop       = rsp_valid && rsp_ready;
   assign has_room  = (count_ff <= CNT_WIDTH'(DEPTH - 2));

   // Second result lands right behind the first when both are present
   assign second_addr = wr_ptr_ff + PTR_WIDTH'(push.first_valid);

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_WIDTH'(push.first_valid)
                            + PTR_WIDTH'(push.second_valid);
      rd_ptr_in = rd_ptr_ff + PTR_WIDTH'(pop);
      count_in  = count_ff + CNT_WIDTH'(push.first_valid)
                           + CNT_WIDTH'(push.second_valid)
                           - CNT_WIDTH'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store incoming results
   always_ff @(posedge clock) begin
      if (push.first_valid) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.second_valid) begin
         entry_ff[second_addr] <= push.second;
      end
   end

endmodule

/* hw/rtl/sorted_coo_duplicate_merge_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_coo_duplicate_merge_top
// Merges runs of equal (row, col) entries in a sorted coordinate stream.
// ----------------------------------------------------------------------------
// An entry is taken in every cycle while the four-entry result queue has room
// for two more results, and its results are registered in the queue before
// they reach rsp_. The result channel delivers one entry per cycle while
// rsp_ready is high, so a stream runs at one entry per cycle except where a
// final entry with new coordinates yields two results. An entry is held
// until the coordinates change or req_last_item arrives; the last result of a
// stream carries rsp_end_of_stream and the number of removed duplicates.
// csr_merge_mode selects keep first (0), keep last (1) or saturating sum (2);
// write it only while the block is idle.
// ----------------------------------------------------------------------------
module sorted_coo_duplicate_merge_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  scm_pkg::index_type  req_row,
   input  scm_pkg::index_type  req_col,
   input  scm_pkg::value_type  req_value,
   input  logic                req_last_item,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output scm_pkg::index_type  rsp_out_row,
   output scm_pkg::index_type  rsp_out_col,
   output scm_pkg::value_type  rsp_out_value,
   output logic                rsp_end_of_stream,
   output scm_pkg::count_type  rsp_removed_count,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  scm_pkg::mode_type   csr_merge_mode
);
   import scm_pkg::*;

   mode_type   mode_ff, mode_in;
   push_type   push;
   result_type rsp_data;
   logic       has_room;
   logic       req_fire;

   assign csr_ready = 1'b1;
   assign req_ready = has_room;
   assign req_fire  = req_valid && req_ready;

   // Hold the merge mode register
   assign mode_in = (csr_valid && csr_ready) ? csr_merge_mode : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_KEEP_FIRST;
      end else begin
         mode_ff <= mode_in;
      end
   end

   scm_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_fire),
      .row        (req_row),
      .col        (req_col),
      .value      (req_value),
      .last_item  (req_last_item),
      .merge_mode (mode_ff),
      .push       (push)
   );

   scm_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .has_room  (has_room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Unpack the result entry onto the ports
   assign rsp_out_row       = rsp_data.row;
   assign rsp_out_col       = rsp_data.col;
   assign rsp_out_value     = rsp_data.value;
   assign rsp_end_of_stream = rsp_data.end_of_stream;
   assign rsp_removed_count = rsp_data.removed_count;

endmodule

/* dv/scm_merge_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scm_merge_checker
// Watches the entry, result and register channels of the duplicate merger,
// predicts the merged entries of every accepted entry and compares each
// delivered result with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module scm_merge_checker
   import scm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  index_type  req_row,
   input  index_type  req_col,
   input  value_type  req_value,
   input  logic       req_last_item,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  index_type  rsp_out_row,
   input  index_type  rsp_out_col,
   input  value_type  rsp_out_value,
   input  logic       rsp_end_of_stream,
   input  count_type  rsp_removed_count,
   input  logic       csr_valid,
   input  logic       csr_ready,
   input  mode_type   csr_merge_mode,
   output int         fail_count,
   output int         results_owed
);

   // Merged entries predicted but not yet delivered, oldest first
   result_type merged_q[$];

   // Shadow of the block: mode register, held entry and duplicate counter
   mode_type  mode_reg;
   index_type held_row;
   index_type held_col;
   value_type held_value;
   logic      held_valid;
   count_type dup_count;
   int        errors;

   // Add two values and clamp to the signed limits
   function automatic value_type clamp_sum(value_type a, value_type b);
      logic signed [VALUE_WIDTH:0] wide;
      wide = $signed({a[VALUE_WIDTH-1], a}) + $signed({b[VALUE_WIDTH-1], b});
      if (wide[VALUE_WIDTH] != wide[VALUE_WIDTH-1]) begin
         if (wide[VALUE_WIDTH])
            return {1'b1, {(VALUE_WIDTH-1){1'b0}}};
         return {1'b0, {(VALUE_WIDTH-1){1'b1}}};
      end
      return wide[VALUE_WIDTH-1:0];
   endfunction

   // Queue the held entry as a merged result
   task automatic emit_held(logic eos, count_type removed);
      result_type res;
      res.row           = held_row;
      res.col           = held_col;
      res.value         = held_value;
      res.end_of_stream = eos;
      res.removed_count = removed;
      merged_q.push_back(res);
   endtask

   // Fold one accepted entry into the held entry, emit on change or flush
   task automatic merge_entry(index_type r, index_type c, value_type v, logic last);
      if (held_valid && r == held_row && c == held_col) begin
         case (mode_reg)
            MODE_KEEP_LAST: held_value = v;
            MODE_SUM:       held_value = clamp_sum(held_value, v);
            default:        ;
         endcase
         if (dup_count != '1)
            dup_count = dup_count + 1'b1;
      end else begin
         if (held_valid)
            emit_held(1'b0, '0);
         held_row   = r;
         held_col   = c;
         held_value = v;
         held_valid = 1'b1;
      end
      if (last) begin
         emit_held(1'b1, dup_count);
         held_row   = '0;
         held_col   = '0;
         held_value = '0;
         held_valid = 1'b0;
         dup_count  = '0;
      end
   endtask

   // Compare one delivered result with the oldest prediction
   task automatic check_result();
      result_type want;
      if (merged_q.size() == 0) begin
         if (errors < 10)
            $display("%0t: unexpected result row=%0d col=%0d value=%0d eos=%0b removed=%0d",
                     $realtime, rsp_out_row, rsp_out_col, rsp_out_value,
                     rsp_end_of_stream, rsp_removed_count);
         errors = errors + 1;
      end else begin
         want = merged_q.pop_front();
         if (rsp_out_row !== want.row || rsp_out_col !== want.col ||
             rsp_out_value !== want.value || rsp_end_of_stream !== want.end_of_stream ||
             rsp_removed_count !== want.removed_count) begin
            if (errors < 10) begin
               $display("%0t: mismatch expected row=%0d col=%0d value=%0d eos=%0b removed=%0d",
                        $realtime, want.row, want.col, want.value,
                        want.end_of_stream, want.removed_count);
               $display("%0t:          actual   row=%0d col=%0d value=%0d eos=%0b removed=%0d",
                        $realtime, rsp_out_row, rsp_out_col, rsp_out_value,
                        rsp_end_of_stream, rsp_removed_count);
            end
            errors = errors + 1;
         end
      end
   endtask

   // Sample every transfer at the clock edge: register, result, then entry
   always @(posedge clock) begin
      if (reset) begin
         mode_reg   = MODE_KEEP_FIRST;
         held_row   = '0;
         held_col   = '0;
         held_value = '0;
         held_valid = 1'b0;
         dup_count  = '0;
         errors     = 0;
         merged_q.delete();
      end else begin
         if (csr_valid && csr_ready)
            mode_reg = csr_merge_mode;
         if (rsp_valid && rsp_ready)
            check_result();
         if (req_valid && req_ready)
            merge_entry(req_row, req_col, req_value, req_last_item);
      end
      fail_count   <= errors;
      results_owed <= merged_q.size();
   end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives sorted coordinate streams into the duplicate merger under every
// merge mode and several idle patterns, and reports the verdict of the
// checker that runs beside the block.
// ----------------------------------------------------------------------------
module tb_top;
   import scm_pkg::*;

   // Mode code the block does not define; it must act as keep first
   localparam mode_type  MODE_UNUSED = 2'd3;
   localparam index_type INDEX_MAX   = '1;
   localparam value_type VALUE_MAX   = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
   localparam value_type VALUE_MIN   = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
   localparam int        PHASE_ITEMS = 168;
   localparam int        SETTLE      = 4;

   logic      clock         = 1'b0;
   logic      reset         = 1'b1;
   logic      req_valid     = 1'b0;
   logic      req_ready;
   index_type req_row       = '0;
   index_type req_col       = '0;
   value_type req_value     = '0;
   logic      req_last_item = 1'b0;
   logic      rsp_valid;
   logic      rsp_ready     = 1'b0;
   index_type rsp_out_row;
   index_type rsp_out_col;
   value_type rsp_out_value;
   logic      rsp_end_of_stream;
   count_type rsp_removed_count;
   logic      csr_valid      = 1'b0;
   logic      csr_ready;
   mode_type  csr_merge_mode = MODE_KEEP_FIRST;

   int fail_count;
   int results_owed;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   // Coordinates of the stream being generated
   index_type gen_row;
   index_type gen_col;

   sorted_coo_duplicate_merge_top DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_row           (req_row),
      .req_col           (req_col),
      .req_value         (req_value),
      .req_last_item     (req_last_item),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_row       (rsp_out_row),
      .rsp_out_col       (rsp_out_col),
      .rsp_out_value     (rsp_out_value),
      .rsp_end_of_stream (rsp_end_of_stream),
      .rsp_removed_count (rsp_removed_count),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_merge_mode    (csr_merge_mode)
   );

   scm_merge_checker merge_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_row           (req_row),
      .req_col           (req_col),
      .req_value         (req_value),
      .req_last_item     (req_last_item),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_row       (rsp_out_row),
      .rsp_out_col       (rsp_out_col),
      .rsp_out_value     (rsp_out_value),
      .rsp_end_of_stream (rsp_end_of_stream),
      .rsp_removed_count (rsp_removed_count),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_merge_mode    (csr_merge_mode),
      .fail_count        (fail_count),
      .results_owed      (results_owed)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Stall the result channel at random
   always @(posedge clock)
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);

   // Present one entry, with a random gap first, and hold it until transfer
   task automatic send_entry(index_type r, index_type c, value_type v, logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_row       <= r;
      req_col       <= c;
      req_value     <= v;
      req_last_item <= last;
      do @(posedge clock); while (!req_ready);
   endtask

   // Hold off entries until every predicted result has been delivered
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_owed != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Write the merge mode once the block is idle
   task automatic write_mode(mode_type m);
      drain_results();
      csr_valid      <= 1'b1;
      csr_merge_mode <= m;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Mix of small values, full-range values and values near the limits
   function automatic value_type pick_value();
      case ($urandom_range(2))
         0:       return value_type'($urandom);
         1:       return value_type'($signed($urandom_range(200)) - 100);
         default: begin
            if ($urandom_range(1))
               return VALUE_MAX - value_type'($urandom_range(255));
            return VALUE_MIN + value_type'($urandom_range(255));
         end
      endcase
   endfunction

   // Start a stream at small or full-range coordinates
   task automatic pick_stream_base();
      if ($urandom_range(1)) begin
         gen_row = index_type'($urandom);
         gen_col = index_type'($urandom);
      end else begin
         gen_row = index_type'($urandom_range(15));
         gen_col = index_type'($urandom_range(15));
      end
   endtask

   // Step the coordinates: mostly duplicates and sorted advances, some noise
   task automatic step_coords();
      int pick;
      pick = $urandom_range(99);
      if (pick < 40) begin
         // keep coordinates: duplicate
      end else if (pick < 85) begin
         gen_col = gen_col + index_type'(1 + $urandom_range(3));
      end else if (pick < 95) begin
         gen_row = gen_row + 1'b1;
         gen_col = index_type'($urandom_range(7));
      end else begin
         gen_row = index_type'($urandom);
         gen_col = index_type'($urandom);
      end
   endtask

   initial begin
      mode_type phase_mode [8];
      int       stream_left;
      logic     last;

      phase_mode[0] = MODE_SUM;
      phase_mode[1] = MODE_KEEP_FIRST;
      phase_mode[2] = MODE_KEEP_LAST;
      phase_mode[3] = MODE_UNUSED;
      phase_mode[4] = MODE_SUM;
      phase_mode[5] = MODE_KEEP_LAST;
      phase_mode[6] = MODE_KEEP_FIRST;
      phase_mode[7] = MODE_SUM;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Summing: saturate high, come back down, saturate low at max coordinates
      write_mode(MODE_SUM);
      send_entry('0, '0, VALUE_MAX, 1'b0);
      send_entry('0, '0, value_type'(5), 1'b0);
      send_entry('0, '0, value_type'(-3), 1'b0);
      send_entry(INDEX_MAX, INDEX_MAX, VALUE_MIN, 1'b0);
      send_entry(INDEX_MAX, INDEX_MAX, value_type'(-1), 1'b1);

      // Keep last, with new coordinates on the final entry
      write_mode(MODE_KEEP_LAST);
      send_entry(index_type'(5), index_type'(7), value_type'(10), 1'b0);
      send_entry(index_type'(5), index_type'(7), value_type'(20), 1'b0);
      send_entry(index_type'(5), index_type'(8), value_type'(30), 1'b1);

      // Keep first, with a duplicate that is not consecutive
      write_mode(MODE_KEEP_FIRST);
      send_entry(index_type'(1), index_type'(1), value_type'(100), 1'b0);
      send_entry(index_type'(1), index_type'(1), value_type'(200), 1'b0);
      send_entry(index_type'(2), index_type'(1), value_type'(300), 1'b0);
      send_entry(index_type'(1), index_type'(1), value_type'(400), 1'b1);

      // Unused mode code, then single-entry streams right after a flush
      write_mode(MODE_UNUSED);
      send_entry(index_type'(9), index_type'(9), value_type'(-7), 1'b0);
      send_entry(index_type'(9), index_type'(9), value_type'(8), 1'b0);
      send_entry(index_type'(9), index_type'(9), value_type'(9), 1'b1);
      send_entry('0, INDEX_MAX, '0, 1'b1);
      send_entry(INDEX_MAX, '0, VALUE_MIN, 1'b1);

      // Random streams, one merge mode and one idle pattern per phase
      for (int p = 0; p < 8; p++) begin
         write_mode(phase_mode[p]);
         case (p % 4)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 46; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 46; end
            default: begin send_idle_pct = 26; recv_stall_pct = 26; end
         endcase
         stream_left = 0;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // Pause mid-stream until all results are out
            if (i == PHASE_ITEMS / 2)
               drain_results();
            if (stream_left == 0) begin
               stream_left = 1 + $urandom_range(39);
               pick_stream_base();
            end else begin
               step_coords();
            end
            last = (stream_left == 1) || (i == PHASE_ITEMS - 1);
            send_entry(gen_row, gen_col, pick_value(), last);
            stream_left = last ? 0 : stream_left - 1;
         end
      end

      drain_results();
      if (fail_count == 0 && results_owed == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   // Give up on a hung run
   initial begin
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
